/* src/assert_macros.svh */
// Assertion helpers shared by the controller and datapath modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

/* src/lcar_pkg.sv */
`default_nettype none
package lcar_pkg;

  // converter word and arithmetic widths
  localparam int SampleBits = 24;
  localparam int BitCntW    = $clog2(SampleBits + 1);
  localparam int SumW       = 32;
  localparam int DivW       = 33;
  localparam int DivCntW    = $clog2(DivW + 1);

  localparam logic [23:0]        ScaleDefault = 24'd218445;
  localparam logic [23:0]        Max24        = 24'hFFFFFF;
  localparam logic signed [23:0] SMax24       = 24'sh7FFFFF;
  localparam logic signed [23:0] SMin24       = 24'sh800000;

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_TARE  = 2'd1;
  localparam logic [1:0] FUNC_WEIGH = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW,
    PH_XRAISE,
    PH_XHIGH
  } phase_e;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_DIV_AVG,
    CT_DIV_GRAMS,
    CT_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] func;
    logic       dout_level;
    logic [7:0] sample_count;
  } in_item_t;

  typedef struct packed {
    logic               sck_level;
    logic               result_valid;
    logic               was_tare;
    logic signed [23:0] raw_average;
    logic [23:0]        grams;
    logic               busy_res;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic avg_done;
    logic out_final;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finish;
    logic div_done;
    logic tare;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

/* src/lcar_ctrl.sv */
`default_nettype none
module lcar_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lcar_pkg::dp_status_t status_i,
  output lcar_pkg::ctrl_cmd_t  cmd_o,
  output logic                in_ready_o
);
  import lcar_pkg::*;
  `include "assert_macros.svh"

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CT_IDLE: begin
        if (accept && status_i.finish) state_d = CT_DIV_AVG;
      end
      CT_DIV_AVG: begin
        if (status_i.div_done) state_d = status_i.tare ? CT_DONE : CT_DIV_GRAMS;
      end
      CT_DIV_GRAMS: begin
        if (status_i.div_done) state_d = CT_DONE;
      end
      CT_DONE: begin
        if (status_i.out_free) state_d = CT_IDLE;
      end
      default: state_d = CT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      CT_IDLE: begin
        in_ready_o   = status_i.out_free;
        cmd_o.accept = accept;
      end
      CT_DIV_AVG: begin
        cmd_o.div_step = !status_i.div_done;
        cmd_o.avg_done = status_i.div_done;
      end
      CT_DIV_GRAMS: begin
        cmd_o.div_step = !status_i.div_done;
      end
      CT_DONE: begin
        cmd_o.out_final = status_i.out_free;
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_tare_skips_grams,
    (state_q == CT_DIV_AVG) && status_i.div_done && status_i.tare |=> state_q == CT_DONE,
    "tare measurement did not skip the grams division")
  `ASSERT_CLK(a_final_returns_idle, cmd_o.out_final |=> state_q == CT_IDLE,
    "controller did not return to idle after final result")
  `ASSERT_NEVER(a_step_and_final, cmd_o.div_step && (cmd_o.out_final || cmd_o.accept),
    "divider step overlaps an output load")

endmodule
`default_nettype wire

/* src/lcar_datapath.sv */
`default_nettype none
module lcar_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcar_pkg::in_item_t   in_data_i,
  input  logic                 cfg_write_i,
  input  logic [23:0]          cfg_data_i,
  input  logic                 out_ready_i,
  input  lcar_pkg::ctrl_cmd_t  cmd_i,
  output lcar_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  output lcar_pkg::out_item_t  out_data_o
);
  import lcar_pkg::*;
  `include "assert_macros.svh"

  // converter sequencing state
  phase_e                 phase_q, phase_d;
  logic [BitCntW-1:0]     bitcnt_q, bitcnt_d, bit_inc;
  logic [SampleBits-1:0]  shift_q, shift_d;
  logic [SumW-1:0]        sum_q, sum_d, sum_add;
  logic [7:0]             left_q, left_d, left_dec;
  logic [7:0]             target_q, target_d;
  logic                   tare_q, tare_d;
  logic signed [23:0]     offset_q;
  logic [23:0]            scale_q;
  logic                   finish;

  // shared restoring divider
  logic [DivW-1:0]        dvd_q;
  logic [23:0]            rem_q, divisor_q, rem_nx;
  logic [DivCntW-1:0]     dcnt_q;
  logic [24:0]            trial;
  logic                   ge;
  logic                   neg_q, scale_zero_q;
  logic signed [23:0]     avg_q, avg_sat;
  logic [DivW-1:0]        sum_mag;
  logic [24:0]            diff, diff_mag;
  logic [DivW-1:0]        grams_dvd;
  logic [23:0]            grams_fin;

  // output register
  logic                   out_valid_q;
  out_item_t              out_q, out_nx;
  logic                   load_tick;

  assign bit_inc  = bitcnt_q + BitCntW'(1);
  assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : left_q;
  assign sum_add  = sum_q + SumW'(signed'(shift_q));

  // next sequencing state for the item at the input
  always_comb begin
    phase_d  = phase_q;
    bitcnt_d = bitcnt_q;
    shift_d  = shift_q;
    sum_d    = sum_q;
    left_d   = left_q;
    target_d = target_q;
    tare_d   = tare_q;
    finish   = 1'b0;
    case (in_data_i.func)
      FUNC_TARE, FUNC_WEIGH: begin
        if (phase_q == PH_IDLE) begin
          target_d = (in_data_i.sample_count == 8'd0) ? 8'd1 : in_data_i.sample_count;
          left_d   = target_d;
          sum_d    = '0;
          shift_d  = '0;
          bitcnt_d = '0;
          tare_d   = (in_data_i.func == FUNC_TARE);
          phase_d  = PH_WAIT;
        end
      end
      FUNC_TICK: begin
        case (phase_q)
          PH_WAIT: begin
            if (!in_data_i.dout_level) begin
              shift_d  = '0;
              bitcnt_d = '0;
              phase_d  = PH_HIGH;
            end
          end
          PH_HIGH: begin
            shift_d  = {shift_q[SampleBits-2:0], in_data_i.dout_level};
            bitcnt_d = bit_inc;
            phase_d  = (bit_inc >= BitCntW'(SampleBits)) ? PH_XRAISE : PH_LOW;
          end
          PH_LOW:    phase_d = PH_HIGH;
          PH_XRAISE: phase_d = PH_XHIGH;
          PH_XHIGH: begin
            sum_d    = sum_add;
            shift_d  = '0;
            bitcnt_d = '0;
            left_d   = left_dec;
            if (left_dec == 8'd0) begin
              finish  = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_WAIT;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  // sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bitcnt_q <= '0;
      shift_q  <= '0;
      sum_q    <= '0;
      left_q   <= '0;
      target_q <= 8'd1;
      tare_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      phase_q  <= phase_d;
      bitcnt_q <= bitcnt_d;
      shift_q  <= shift_d;
      sum_q    <= sum_d;
      left_q   <= left_d;
      target_q <= target_d;
      tare_q   <= tare_d;
    end
  end

  // zero offset and scale; tare restores the default scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      scale_q  <= ScaleDefault;
    end else if (cmd_i.avg_done && tare_q) begin
      offset_q <= avg_sat;
      scale_q  <= ScaleDefault;
    end else if (cfg_write_i) begin
      scale_q  <= cfg_data_i;
    end
  end

  // divider operands
  assign sum_mag   = sum_d[SumW-1] ? DivW'(-{sum_d[SumW-1], sum_d}) : {1'b0, sum_d};
  assign diff      = {avg_sat[23], avg_sat} - {offset_q[23], offset_q};
  assign diff_mag  = diff[24] ? -diff : diff;
  assign grams_dvd = {diff_mag, 8'd0};

  // one quotient bit per cycle
  assign trial  = {rem_q, dvd_q[DivW-1]};
  assign ge     = (trial >= {1'b0, divisor_q});
  assign rem_nx = ge ? 24'(trial - {1'b0, divisor_q}) : trial[23:0];

  // signed average from quotient magnitude, saturated
  always_comb begin
    if (!neg_q) begin
      avg_sat = (dvd_q > DivW'(SMax24)) ? SMax24 : signed'(dvd_q[23:0]);
    end else begin
      avg_sat = (dvd_q > DivW'(24'h800000)) ? SMin24 : signed'(~dvd_q[23:0] + 24'd1);
    end
  end

  always_comb begin
    if (tare_q) begin
      grams_fin = '0;
    end else if (scale_zero_q) begin
      grams_fin = Max24;
    end else begin
      grams_fin = (dvd_q > DivW'(Max24)) ? Max24 : dvd_q[23:0];
    end
  end

  // divider count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if ((cmd_i.accept && finish) || cmd_i.avg_done) begin
      dcnt_q <= DivCntW'(DivW);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - DivCntW'(1);
    end
  end

  // divider data
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && finish) begin
      dvd_q     <= sum_mag;
      rem_q     <= '0;
      divisor_q <= {16'd0, target_q};
      neg_q     <= sum_d[SumW-1];
    end else if (cmd_i.avg_done) begin
      avg_q        <= avg_sat;
      dvd_q        <= grams_dvd;
      rem_q        <= '0;
      divisor_q    <= scale_q;
      scale_zero_q <= (scale_q == 24'd0);
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DivW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  // result item
  assign load_tick = cmd_i.accept && !finish;

  always_comb begin
    out_nx = '0;
    if (cmd_i.out_final) begin
      out_nx.result_valid = 1'b1;
      out_nx.was_tare     = tare_q;
      out_nx.raw_average  = avg_q;
      out_nx.grams        = grams_fin;
    end else begin
      out_nx.sck_level = (phase_d == PH_HIGH) || (phase_d == PH_XHIGH);
      out_nx.busy_res  = (phase_d != PH_IDLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_tick || cmd_i.out_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_tick || cmd_i.out_final) out_q <= out_nx;
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.finish   = finish;
  assign status_o.div_done = (dcnt_q == '0);
  assign status_o.tare     = tare_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  `ASSERT_CLK(a_div_armed, cmd_i.accept && finish |=> dcnt_q == DivCntW'(DivW),
    "divider not armed on closing item")
  `ASSERT_CLK(a_final_valid, cmd_i.out_final |=> out_valid_q && out_q.result_valid,
    "final measurement not presented")
  `ASSERT_CLK(a_tick_no_result, load_tick |=> out_valid_q && !out_q.result_valid,
    "ordinary item reported a measurement")

endmodule
`default_nettype wire

/* src/load_cell_adc_reader.sv */
// An ordinary item's result is registered on acceptance and output in the next cycle.
// The item closing a weigh measurement starts a divide of the sample sum by the count,
// then a divide by the scale; a tare skips the second divide.
// Throughput: one item per cycle while the output is free; input stalls during divides.
// Reset (rst_ni, async, active low): idle, zero offset, scale back to 218445.
`default_nettype none
module load_cell_adc_reader (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lcar_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lcar_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [23:0]         cfg_data_i
);
  import lcar_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_write;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  lcar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  lcar_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_write_i (cfg_write),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
